### src/fds_pkg.sv
// Shared types and constants for the feature distance score block.
// Used by every module under src; depends on nothing else.
`default_nettype none
package fds_pkg;

    localparam int unsigned SCORE_W   = 48;
    localparam int unsigned DEV_W     = 31;
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned WEIGHT_W  = 18;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 32;
    localparam int unsigned DIV_STEPS = 48;
    localparam int unsigned DIV_CNT_W = 6;

    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_GEO_MIN_DEV  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERN_MIN_DEV = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GEO_WEIGHT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERN_WEIGHT  = 8'd3;

    localparam logic [DEV_W-1:0]    RST_GEO_MIN_DEV  = 31'd655;
    localparam logic [DEV_W-1:0]    RST_ZERN_MIN_DEV = 31'd66;
    localparam logic [WEIGHT_W-1:0] RST_GEO_WEIGHT   = 18'd45875;
    localparam logic [WEIGHT_W-1:0] RST_ZERN_WEIGHT  = 18'd65536;

    localparam logic KIND_GEO  = 1'b0;
    localparam logic KIND_ZERN = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic signed [VALUE_W-1:0] sample_value;
        logic signed [VALUE_W-1:0] mean_value;
        logic [DEV_W-1:0]          deviation;
        logic                      last;
    } item_t;

    typedef struct packed {
        logic [SCORE_W-1:0] total_score;
        logic [SCORE_W-1:0] geometric_score;
        logic [SCORE_W-1:0] zernike_score;
    } result_t;

    // One classified element waiting for the arithmetic back end.
    typedef struct packed {
        logic               active;
        logic               kind;
        logic               last;
        logic [VALUE_W-1:0] mag;
        logic [DEV_W-1:0]   dev;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic busy;
        logic emitting;
    } back_stat_t;

endpackage
`default_nettype wire

### src/fds_front.sv
// Front end: takes input beats, forms |sample - mean| and decides whether the
// element counts. Depends on fds_pkg.
`default_nettype none
module fds_front (
    input  wire fds_pkg::item_t     item,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic [30:0]        geo_min_dev,
    input  wire logic [30:0]        zern_min_dev,
    input  wire fds_pkg::queue_stat_t q_stat,
    output logic                    push,
    output fds_pkg::job_t           job
);
    import fds_pkg::*;

    logic signed [VALUE_W:0] diff;
    logic [VALUE_W:0]        neg;
    logic [DEV_W-1:0]        min_dev;

    always_comb
    begin
        diff    = {item.sample_value[VALUE_W-1], item.sample_value}
                - {item.mean_value[VALUE_W-1], item.mean_value};
        neg     = -diff;
        min_dev = (item.kind == KIND_ZERN) ? zern_min_dev : geo_min_dev;

        job.active = item.deviation > min_dev;
        job.kind   = item.kind;
        job.last   = item.last;
        job.mag    = diff[VALUE_W] ? neg[VALUE_W-1:0] : diff[VALUE_W-1:0];
        job.dev    = item.deviation;
    end

    assign item_stall = q_stat.full;
    assign push       = item_valid && !q_stat.full;

endmodule
`default_nettype wire

### src/fds_queue.sv
// Small FIFO between front and back end so each side stalls on its own.
// Depends on fds_pkg.
`default_nettype none
module fds_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire fds_pkg::job_t wr_job,
    input  wire logic          pop,
    output fds_pkg::job_t      rd_job,
    output fds_pkg::queue_stat_t stat
);
    import fds_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    assign rd_job     = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule
`default_nettype wire

### src/fds_back.sv
// Back end: squares, divides one quotient bit per cycle, accumulates, and on
// the last element weights the sums into the output register. Uses fds_pkg.
`default_nettype none
module fds_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire fds_pkg::job_t job,
    input  wire logic          job_avail,
    output logic               job_pop,
    input  wire logic [17:0]   geo_weight,
    input  wire logic [17:0]   zern_weight,
    output logic               result_valid,
    input  wire logic          result_stall,
    output fds_pkg::result_t   result,
    output fds_pkg::back_stat_t stat
);
    import fds_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_MUL  = 9'b000000010,
        ST_CHK  = 9'b000000100,
        ST_DIV  = 9'b000001000,
        ST_ACC  = 9'b000010000,
        ST_WGEO = 9'b000100000,
        ST_WZRN = 9'b001000000,
        ST_SUM  = 9'b010000000,
        ST_FIN  = 9'b100000000
    } state_t;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

    state_t               state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SCORE_W-1:0]   geo_acc_reg, geo_acc_next;
    logic [SCORE_W-1:0]   zern_acc_reg, zern_acc_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    job_t                 job_reg, job_next;
    logic [63:0]          nsq_reg, nsq_next;
    logic [61:0]          dsq_reg, dsq_next;
    logic [61:0]          rem_reg, rem_next;
    logic [47:0]          sh_reg, sh_next;
    logic [SCORE_W-1:0]   quo_reg, quo_next;
    logic [49:0]          pg_hi_reg, pg_hi_next, pz_hi_reg, pz_hi_next;
    logic [33:0]          pg_lo_reg, pg_lo_next, pz_lo_reg, pz_lo_next;
    logic [50:0]          hi_reg, hi_next;
    logic [34:0]          lo_reg, lo_next;
    result_t              out_reg, out_next;

    logic [62:0]          trial;
    logic [62:0]          trial_diff;
    logic                 trial_ge;
    logic [SCORE_W:0]     acc_sum;
    logic [SCORE_W-1:0]   acc_sel;
    logic [51:0]          total;
    logic                 out_free;

    always_comb
    begin
        trial      = {rem_reg, sh_reg[47]};
        trial_diff = trial - {1'b0, dsq_reg};
        trial_ge   = trial >= {1'b0, dsq_reg};
        acc_sel    = (job_reg.kind == KIND_ZERN) ? zern_acc_reg : geo_acc_reg;
        acc_sum    = {1'b0, acc_sel} + {1'b0, quo_reg};
        total      = {1'b0, hi_reg} + {33'd0, lo_reg[34:16]};
        out_free   = !out_valid_reg || !result_stall;

        state_next     = state_reg;
        out_valid_next = out_valid_reg && result_stall;
        geo_acc_next   = geo_acc_reg;
        zern_acc_next  = zern_acc_reg;
        cnt_next       = cnt_reg;
        job_next       = job_reg;
        nsq_next       = nsq_reg;
        dsq_next       = dsq_reg;
        rem_next       = rem_reg;
        sh_next        = sh_reg;
        quo_next       = quo_reg;
        pg_hi_next     = pg_hi_reg;
        pg_lo_next     = pg_lo_reg;
        pz_hi_next     = pz_hi_reg;
        pz_lo_next     = pz_lo_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        out_next       = out_reg;
        job_pop        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_avail)
                begin
                    job_pop  = 1'b1;
                    job_next = job;
                    if (job.active)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (job.last)
                    begin
                        state_next = ST_WGEO;
                    end
                end
            end
            ST_MUL:
            begin
                nsq_next   = job_reg.mag * job_reg.mag;
                dsq_next   = job_reg.dev * job_reg.dev;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                // A whole part of 2^32 or more cannot fit the Q32.16 term.
                if ({30'd0, nsq_reg[63:32]} >= dsq_reg)
                begin
                    quo_next   = SCORE_MAX;
                    state_next = ST_ACC;
                end
                else
                begin
                    rem_next   = {30'd0, nsq_reg[63:32]};
                    sh_next    = {nsq_reg[31:0], 16'd0};
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = trial_ge ? trial_diff[61:0] : trial[61:0];
                sh_next  = {sh_reg[46:0], 1'b0};
                quo_next = {quo_reg[SCORE_W-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (job_reg.kind == KIND_ZERN)
                begin
                    zern_acc_next = acc_sum[SCORE_W] ? SCORE_MAX : acc_sum[SCORE_W-1:0];
                end
                else
                begin
                    geo_acc_next = acc_sum[SCORE_W] ? SCORE_MAX : acc_sum[SCORE_W-1:0];
                end
                state_next = job_reg.last ? ST_WGEO : ST_IDLE;
            end
            ST_WGEO:
            begin
                pg_hi_next = geo_weight * geo_acc_reg[47:16];
                pg_lo_next = geo_weight * geo_acc_reg[15:0];
                state_next = ST_WZRN;
            end
            ST_WZRN:
            begin
                pz_hi_next = zern_weight * zern_acc_reg[47:16];
                pz_lo_next = zern_weight * zern_acc_reg[15:0];
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                hi_next    = {1'b0, pg_hi_reg} + {1'b0, pz_hi_reg};
                lo_next    = {1'b0, pg_lo_reg} + {1'b0, pz_lo_reg};
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_next.total_score     = (total[51:48] != '0) ? SCORE_MAX
                                                                    : total[47:0];
                    out_next.geometric_score = geo_acc_reg;
                    out_next.zernike_score   = zern_acc_reg;
                    geo_acc_next             = '0;
                    zern_acc_next            = '0;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            geo_acc_reg   <= '0;
            zern_acc_reg  <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            geo_acc_reg   <= geo_acc_next;
            zern_acc_reg  <= zern_acc_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        nsq_reg   <= nsq_next;
        dsq_reg   <= dsq_next;
        rem_reg   <= rem_next;
        sh_reg    <= sh_next;
        quo_reg   <= quo_next;
        pg_hi_reg <= pg_hi_next;
        pg_lo_reg <= pg_lo_next;
        pz_hi_reg <= pz_hi_next;
        pz_lo_reg <= pz_lo_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        out_reg   <= out_next;
    end

    assign result_valid  = out_valid_reg;
    assign result        = out_reg;
    assign stat.busy     = (state_reg != ST_IDLE);
    assign stat.emitting = (state_reg == ST_FIN) && out_free;

endmodule
`default_nettype wire

### src/feature_distance_score_core.sv
// Top level of the feature distance score block: configuration registers,
// front end, job queue and arithmetic back end. Depends on fds_pkg.
//
// Use: feature elements enter on the item channel (item_valid/item_stall);
// one beat is accepted when item_valid is high and item_stall low. Each
// counted element's normalized squared error joins its kind's sum; on the
// element flagged last a result beat (total, geometric and Zernike
// scores) is offered on the result channel, held until result_stall is low.
// Configuration writes use cfg_valid/cfg_ready with cfg_index/cfg_data and
// are always ready; write only while the block is idle.
// An element that counts occupies the back end for pop, square, range
// check, 48 one-bit restoring divide steps (bypassed on saturation) and
// accumulate; a skipped element is only popped. The last element then
// passes through weighting before the result register loads. The back end
// takes no new element until done with the last; a QUEUE_DEPTH-entry queue
// lets new elements enter while it works. Reset clears both sums, loads the
// default registers and empties the queue. A stalled result holds the back
// end in its final step, and the queue then fills and raises item_stall.
`default_nettype none
module feature_distance_score_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire fds_pkg::item_t   item,
    input  wire logic             item_valid,
    output logic                  item_stall,
    output fds_pkg::result_t      result,
    output logic                  result_valid,
    input  wire logic             result_stall,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [7:0]       cfg_index,
    input  wire logic [31:0]      cfg_data
);
    import fds_pkg::*;

    logic [DEV_W-1:0]    geo_min_dev_reg, zern_min_dev_reg;
    logic [WEIGHT_W-1:0] geo_weight_reg, zern_weight_reg;

    job_t        front_job, queue_job;
    logic        push, pop;
    queue_stat_t q_stat;
    back_stat_t  b_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geo_min_dev_reg  <= RST_GEO_MIN_DEV;
            zern_min_dev_reg <= RST_ZERN_MIN_DEV;
            geo_weight_reg   <= RST_GEO_WEIGHT;
            zern_weight_reg  <= RST_ZERN_WEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GEO_MIN_DEV:  geo_min_dev_reg  <= cfg_data[DEV_W-1:0];
                CFG_ZERN_MIN_DEV: zern_min_dev_reg <= cfg_data[DEV_W-1:0];
                CFG_GEO_WEIGHT:   geo_weight_reg   <= cfg_data[WEIGHT_W-1:0];
                CFG_ZERN_WEIGHT:  zern_weight_reg  <= cfg_data[WEIGHT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    fds_front u_front (
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .geo_min_dev  (geo_min_dev_reg),
        .zern_min_dev (zern_min_dev_reg),
        .q_stat       (q_stat),
        .push         (push),
        .job          (front_job)
    );

    fds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (front_job),
        .pop    (pop),
        .rd_job (queue_job),
        .stat   (q_stat)
    );

    fds_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (queue_job),
        .job_avail    (!q_stat.empty),
        .job_pop      (pop),
        .geo_weight   (geo_weight_reg),
        .zern_weight  (zern_weight_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .stat         (b_stat)
    );

    // The queue can never report full and empty together.
    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty at once");

    // An accepted beat always found room in the queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |-> !q_stat.full)
        else $error("item accepted into a full queue");

    // A new result beat appears only right after the back end emitted it.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(b_stat.emitting))
        else $error("result appeared without the back end emitting");

    // Popping the queue only happens from an idle back end with data waiting.
    a_pop_legal: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!b_stat.busy && !q_stat.empty))
        else $error("queue popped while back end busy or queue empty");

endmodule
`default_nettype wire

### dv/tb.sv
// Self-checking testbench for feature_distance_score_core.
// Drives directed and random feature elements and compares every score beat
// against a local model of the block. Depends on fds_pkg and the RTL under src.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fds_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES   = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    item_t item = '0;
    logic item_valid = 1'b0;
    logic item_stall;
    result_t result;
    logic result_valid;
    logic result_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    feature_distance_score_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .item(item), .item_valid(item_valid), .item_stall(item_stall),
        .result(result), .result_valid(result_valid), .result_stall(result_stall),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Local copy of the block's registers and sums.
    logic [DEV_W-1:0]    m_geo_min, m_zern_min;
    logic [WEIGHT_W-1:0] m_geo_w, m_zern_w;
    logic [SCORE_W-1:0]  m_geo_sum, m_zern_sum;

    result_t score_q[$];
    int unsigned errors = 0;
    int unsigned idle_cycles = 0;
    bit stall_mode_on = 1'b1;

    task automatic report_mismatch(input string what, input logic [SCORE_W-1:0] got,
                                   input logic [SCORE_W-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [SCORE_W-1:0] norm_sq_err(input logic [32:0] mag,
                                                      input logic [DEV_W-1:0] dev);
        logic [63:0] num, den, whole, rem, frac;
        num = mag * mag;
        den = dev * dev;
        whole = num / den;
        rem = num % den;
        frac = 0;
        if (whole > 64'hFFFF_FFFF)
            return SCORE_MAX;
        for (int i = 0; i < 16; i++)
        begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                frac[0] = 1'b1;
            end
        end
        return {whole[31:0], frac[15:0]};
    endfunction

    function automatic logic [SCORE_W-1:0] add_sat(input logic [SCORE_W-1:0] a,
                                                  input logic [SCORE_W-1:0] b);
        logic [SCORE_W:0] s;
        s = a + b;
        return s[SCORE_W] ? SCORE_MAX : s[SCORE_W-1:0];
    endfunction

    // Returns 1 and the expected beat when the element closes a symbol.
    function automatic bit score_element(input item_t it, output result_t r);
        logic signed [32:0] d;
        logic [32:0] mag;
        logic [DEV_W-1:0] lim;
        logic [67:0] hi, lo, tot;
        lim = (it.kind == KIND_ZERN) ? m_zern_min : m_geo_min;
        if (it.deviation > lim)
        begin
            d = $signed({it.sample_value[31], it.sample_value})
              - $signed({it.mean_value[31], it.mean_value});
            mag = d[32] ? -d : d;
            if (it.kind == KIND_ZERN)
                m_zern_sum = add_sat(m_zern_sum, norm_sq_err(mag, it.deviation));
            else
                m_geo_sum = add_sat(m_geo_sum, norm_sq_err(mag, it.deviation));
        end
        r = '0;
        if (!it.last)
            return 1'b0;
        hi = m_geo_w * m_geo_sum[47:16] + m_zern_w * m_zern_sum[47:16];
        lo = m_geo_w * m_geo_sum[15:0] + m_zern_w * m_zern_sum[15:0];
        tot = hi + (lo >> 16);
        r.total_score = (tot > SCORE_MAX) ? SCORE_MAX : tot[SCORE_W-1:0];
        r.geometric_score = m_geo_sum;
        r.zernike_score = m_zern_sum;
        m_geo_sum = '0;
        m_zern_sum = '0;
        return 1'b1;
    endfunction

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_GEO_MIN_DEV:  m_geo_min = val[DEV_W-1:0];
            CFG_ZERN_MIN_DEV: m_zern_min = val[DEV_W-1:0];
            CFG_GEO_WEIGHT:   m_geo_w = val[WEIGHT_W-1:0];
            CFG_ZERN_WEIGHT:  m_zern_w = val[WEIGHT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Sends one element; with keep_valid set, valid stays high across back-to-back beats.
    task automatic send_element(input item_t it, input bit keep_valid);
        result_t r;
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (score_element(it, r))
            score_q.push_back(r);
        @(negedge clk);
        if (!keep_valid)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        while (score_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h0} | $urandom_range(0, 3);
            default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        endcase
    endfunction

    function automatic item_t rand_element(input bit is_last);
        item_t it;
        it.kind = $urandom_range(0, 1);
        it.sample_value = rand_value();
        it.mean_value = ($urandom_range(0, 3) == 0) ? rand_value()
                        : it.sample_value + $urandom_range(0, 32'h4_0000) - 32'h2_0000;
        case ($urandom_range(0, 5))
            0: it.deviation = $urandom();
            1: it.deviation = $urandom_range(0, 1000);
            2: it.deviation = $urandom_range(1, 16);
            default: it.deviation = $urandom_range(600, 32'h0008_0000);
        endcase
        it.last = is_last;
        return it;
    endfunction

    // Directed rows: kind, sample, mean, deviation, last, check of expected values.
    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } dir_row_t;

    dir_row_t dir_rows[$];

    task automatic add_row(input logic k, input logic [31:0] s, input logic [31:0] m,
                           input logic [30:0] dv, input logic l, input bit typed,
                           input logic [47:0] t, input logic [47:0] g, input logic [47:0] z);
        dir_row_t row;
        row.it = '{kind: k, sample_value: s, mean_value: m, deviation: dv, last: l};
        row.typed = typed;
        row.want = '{total_score: t, geometric_score: g, zernike_score: z};
        dir_rows.push_back(row);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (score_q.size() == 0)
            begin
                $display("unexpected score beat at %0t", $realtime);
                errors++;
            end
            else
            begin
                result_t w;
                w = score_q.pop_front();
                if (result.total_score !== w.total_score)
                    report_mismatch("total_score", result.total_score, w.total_score);
                if (result.geometric_score !== w.geometric_score)
                    report_mismatch("geometric_score", result.geometric_score, w.geometric_score);
                if (result.zernike_score !== w.zernike_score)
                    report_mismatch("zernike_score", result.zernike_score, w.zernike_score);
            end
        end
    end

    // Receiver stall pattern: runs of stalls with quiet stretches between.
    always @(negedge clk)
    begin
        if (!stall_mode_on)
            result_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 6)
            result_stall <= ~result_stall;
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        result_t r;
        int n_sent;
        int sym_len;
        m_geo_min = RST_GEO_MIN_DEV;
        m_zern_min = RST_ZERN_MIN_DEV;
        m_geo_w = RST_GEO_WEIGHT;
        m_zern_w = RST_ZERN_WEIGHT;
        m_geo_sum = '0;
        m_zern_sum = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Symbol with nothing counted scores zero right after reset.
        add_row(KIND_GEO, 32'h0001_0000, 32'h0, 31'd655, 1'b1, 1'b1, 48'h0, 48'h0, 48'h0);
        // Error of one deviation gives exactly one per kind.
        add_row(KIND_ZERN, 32'h0002_0000, 32'h0001_0000, 31'h1_0000, 1'b0, 1'b0, 0, 0, 0);
        add_row(KIND_GEO, 32'h0002_0000, 32'h0001_0000, 31'h1_0000, 1'b1, 1'b1,
                48'h1_B333, 48'h1_0000, 48'h1_0000);
        // Zero deviation is skipped for both kinds.
        add_row(KIND_ZERN, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0, 1'b0, 1'b0, 0, 0, 0);
        add_row(KIND_GEO, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0, 1'b1, 1'b1, 0, 0, 0);
        // Largest difference over the smallest counted deviation saturates.
        add_row(KIND_GEO, 32'h7FFF_FFFF, 32'h8000_0000, 31'd656, 1'b0, 1'b0, 0, 0, 0);
        add_row(KIND_ZERN, 32'h8000_0000, 32'h7FFF_FFFF, 31'd67, 1'b1, 1'b0, 0, 0, 0);
        // Largest deviation, equal values, and just at the minimum.
        add_row(KIND_GEO, 32'h1234_5678, 32'h1234_5678, 31'h7FFF_FFFF, 1'b0, 1'b0, 0, 0, 0);
        add_row(KIND_ZERN, 32'hFFFF_0000, 32'h0001_0000, 31'd66, 1'b0, 1'b0, 0, 0, 0);
        add_row(KIND_ZERN, 32'hFFFF_0000, 32'h0001_0000, 31'h7FFF_FFFF, 1'b1, 1'b0, 0, 0, 0);
        add_row(KIND_GEO, 32'h8000_0000, 32'h0000_0000, 31'd1000, 1'b0, 1'b0, 0, 0, 0);
        add_row(KIND_GEO, 32'h0000_0001, 32'hFFFF_FFFF, 31'd700, 1'b1, 1'b0, 0, 0, 0);

        foreach (dir_rows[i])
        begin
            send_element(dir_rows[i].it, 1'b0);
            if (dir_rows[i].typed)
            begin
                r = score_q[$];
                if (r.total_score !== dir_rows[i].want.total_score
                    || r.geometric_score !== dir_rows[i].want.geometric_score
                    || r.zernike_score !== dir_rows[i].want.zernike_score)
                    report_mismatch("directed row", r.total_score, dir_rows[i].want.total_score);
            end
        end
        wait_idle();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin
                    write_reg(CFG_GEO_MIN_DEV, 32'h0);
                    write_reg(CFG_ZERN_MIN_DEV, 32'h0);
                    write_reg(CFG_GEO_WEIGHT, 32'h0);
                    write_reg(CFG_ZERN_WEIGHT, 32'h0);
                end
                1: begin
                    write_reg(CFG_GEO_MIN_DEV, 32'hFFFF_FFFF);
                    write_reg(CFG_ZERN_MIN_DEV, 32'd100);
                    write_reg(CFG_GEO_WEIGHT, 32'hFFFF_FFFF);
                    write_reg(CFG_ZERN_WEIGHT, 32'd131072);
                end
                2: begin
                    write_reg(CFG_GEO_MIN_DEV, 32'd655);
                    write_reg(CFG_ZERN_MIN_DEV, 32'h7FFF_FFFF);
                    write_reg(CFG_GEO_WEIGHT, 32'd131072);
                    write_reg(CFG_ZERN_WEIGHT, 32'h3FFFF);
                    write_reg(8'd200, 32'hDEAD_BEEF);
                end
                default: begin
                    write_reg(CFG_GEO_MIN_DEV, $urandom_range(0, 4000));
                    write_reg(CFG_ZERN_MIN_DEV, $urandom_range(0, 4000));
                    write_reg(CFG_GEO_WEIGHT, $urandom_range(0, 131072));
                    write_reg(CFG_ZERN_WEIGHT, $urandom_range(0, 32'h3FFFF));
                end
            endcase
            stall_mode_on = (phase != 3);
            n_sent = 0;
            while (n_sent < 256)
            begin
                sym_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                      : $urandom_range(1, 6);
                for (int k = 0; k < sym_len; k++)
                begin
                    bit burst;
                    burst = (phase == 3) || ($urandom_range(0, 2) != 0);
                    send_element(rand_element(k == sym_len - 1), burst && (k != sym_len - 1));
                    n_sent++;
                    if (!burst)
                        repeat ($urandom_range(1, 8)) @(negedge clk);
                end
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 40)) @(negedge clk);
            end
            wait_idle();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
